@@ hdl/drr_pkg.sv @@
package drr_pkg;

  // Number of packet queues served by the scheduler.
  localparam int NUM_Q = 3;

  // Previous-queue marker meaning that no queue has been visited yet.
  localparam logic [1:0] QUEUE_NONE = 2'd3;

  // Reset value of every quantum register.
  localparam logic [15:0] QUANTUM_RESET = 16'd1500;

  // Command codes carried by an input item.
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_FINISH  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_QUANTUM_0 = 2'd0;
  localparam logic [1:0] REG_QUANTUM_1 = 2'd1;
  localparam logic [1:0] REG_QUANTUM_2 = 2'd2;

  // One classified item handed from the front part to the scheduling engine.
  typedef struct packed {
    logic             finish;
    logic             dropped;
    logic [NUM_Q-1:0] nonempty;
  } job_t;

  // Link status kept by the scheduling engine and used by the front part to pop.
  typedef struct packed {
    logic       busy;
    logic [1:0] queue;
  } link_t;

endpackage

@@ hdl/drr_ram.sv @@
module drr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/drr_front.sv @@
module drr_front import drr_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int SIZE_BITS   = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  cmd,
  input  logic [1:0]                            queue_sel,
  input  logic [15:0]                           packet_size,
  input  link_t                                 link,
  input  logic                                  job_full,
  output logic                                  job_push,
  output job_t                                  job,
  output logic                                  ram_we,
  output logic [$clog2(NUM_Q*QUEUE_DEPTH)-1:0]  ram_waddr,
  output logic [SIZE_BITS-1:0]                  ram_wdata,
  output logic [$clog2(NUM_Q*QUEUE_DEPTH)-1:0]  head_addr [NUM_Q]
);

  localparam int AW = $clog2(NUM_Q * QUEUE_DEPTH);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = SIZE_BITS;

  logic [PW-1:0] head_ptr [NUM_Q];
  logic [PW-1:0] tail_ptr [NUM_Q];
  logic [FW-1:0] fill     [NUM_Q];

  logic          pending;
  logic          pend_drop;
  logic          pend_finish;

  logic          room;
  logic          pop_ok;
  logic [PW-1:0] tail_sel;
  logic          enq_ok;
  logic          pop;
  logic [SW+15:0] size_ext;

  // Per-queue selection of the addressed FIFO and of the FIFO in transmission.
  always_comb begin
    room     = 1'b0;
    pop_ok   = 1'b0;
    tail_sel = '0;
    for (int q = 0; q < NUM_Q; q++) begin
      if (queue_sel == 2'(q)) begin
        room     = fill[q] != FW'(QUEUE_DEPTH);
        tail_sel = tail_ptr[q];
      end
      if (link.queue == 2'(q)) begin
        pop_ok = fill[q] != '0;
      end
    end
  end

  assign enq_ok = in_valid && (cmd == CMD_ENQUEUE) && room;
  assign pop    = in_valid && (cmd == CMD_FINISH) && link.busy && pop_ok;

  assign size_ext  = {{SW{1'b0}}, packet_size};
  assign ram_we    = enq_ok;
  assign ram_waddr = AW'(queue_sel) * AW'(QUEUE_DEPTH) + AW'(tail_sel);
  assign ram_wdata = size_ext[SW-1:0];

  always_comb begin
    for (int q = 0; q < NUM_Q; q++) begin
      head_addr[q] = AW'(q * QUEUE_DEPTH) + AW'(head_ptr[q]);
    end
  end

  assign job_push = pending && !job_full;

  always_comb begin
    job.finish  = pend_finish;
    job.dropped = pend_drop;
    for (int q = 0; q < NUM_Q; q++) begin
      job.nonempty[q] = fill[q] != '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= 1'b0;
      pend_drop   <= 1'b0;
      pend_finish <= 1'b0;
      for (int q = 0; q < NUM_Q; q++) begin
        head_ptr[q] <= '0;
        tail_ptr[q] <= '0;
        fill[q]     <= '0;
      end
    end else begin
      for (int q = 0; q < NUM_Q; q++) begin
        if (enq_ok && queue_sel == 2'(q)) begin
          tail_ptr[q] <= (tail_ptr[q] == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_ptr[q] + 1'b1;
          fill[q]     <= fill[q] + 1'b1;
        end
        if (pop && link.queue == 2'(q)) begin
          head_ptr[q] <= (head_ptr[q] == PW'(QUEUE_DEPTH - 1)) ? '0 : head_ptr[q] + 1'b1;
          fill[q]     <= fill[q] - 1'b1;
        end
      end
      if (in_valid) begin
        pending     <= 1'b1;
        pend_drop   <= (cmd == CMD_ENQUEUE) && !room;
        pend_finish <= cmd == CMD_FINISH;
      end else if (job_push) begin
        pending <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/drr_jobq.sv @@
module drr_jobq import drr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t pop_data,
  output logic full,
  output logic empty
);

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        entry[wr_ptr] <= push_data;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/drr_div.sv @@
module drr_div #(
  parameter int W = 17
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quot
);

  localparam int CW = $clog2(W + 1);

  logic          running;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  dsr;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  // Restoring division, one quotient bit per cycle.
  assign shifted = {rem, quot[W-1]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        quot    <= num;
        dsr     <= den;
      end else if (running) begin
        if (!trial[W]) begin
          rem  <= trial[W-1:0];
          quot <= {quot[W-2:0], 1'b1};
        end else begin
          rem  <= shifted[W-1:0];
          quot <= {quot[W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/drr_back.sv @@
module drr_back import drr_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int SIZE_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 job_valid,
  input  job_t                                 job,
  output logic                                 job_pop,
  input  logic [15:0]                          quantum [NUM_Q],
  input  logic [$clog2(NUM_Q*QUEUE_DEPTH)-1:0] head_addr [NUM_Q],
  output logic [$clog2(NUM_Q*QUEUE_DEPTH)-1:0] ram_raddr,
  input  logic [SIZE_BITS-1:0]                 ram_rdata,
  output link_t                                link,
  output logic                                 done,
  output logic                                 grant_valid,
  output logic [1:0]                           grant_queue,
  output logic [15:0]                          grant_size,
  output logic                                 dropped,
  output logic                                 link_busy
);

  localparam int SW  = SIZE_BITS;
  localparam int DW  = SW + 1;
  localparam int NW  = ((SW > 16) ? SW : 16) + 1;
  localparam int SMW = ((DW > 16) ? DW : 16) + 1;
  localparam int MW  = SW + 16;
  localparam int PW  = SW + 17;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_ADD, S_CHECK, S_DSEL, S_DWAIT, S_MUL, S_ACC, S_FINAL
  } state_t;

  state_t         state;
  logic [DW-1:0]  deficit [NUM_Q];
  logic [SW-1:0]  heads   [NUM_Q];
  logic [1:0]     cur;
  logic [1:0]     prev;
  logic           lbusy;
  logic [NUM_Q-1:0] nonempty;
  logic           drop_r;
  logic [1:0]     rd_cnt;
  logic [1:0]     pass_cnt;
  logic [1:0]     k;
  logic [1:0]     idx;
  logic           found;
  logic [SW-1:0]  best;
  logic [1:0]     kw;
  logic [1:0]     w;
  logic [MW-1:0]  prod;

  logic           busy_now;
  logic [SMW-1:0] add_sum;
  logic [DW-1:0]  add_sat;
  logic [PW-1:0]  acc_sum;
  logic [DW-1:0]  acc_sat;
  logic [SW-1:0]  rounds;
  logic [NW-1:0]  div_num;
  logic           div_start;
  logic           div_done;
  logic [NW-1:0]  div_quot;
  logic [SW-1:0]  r_new;
  logic [SW+15:0] ext_cur;
  logic [SW+15:0] ext_w;
  logic           idx_ok;

  function automatic logic [1:0] next_q(input logic [1:0] q);
    case (q)
      2'd0:    next_q = 2'd1;
      2'd1:    next_q = 2'd2;
      default: next_q = 2'd0;
    endcase
  endfunction

  function automatic logic [15:0] quant_sel(input logic [1:0] q,
                                            input logic [15:0] qv [NUM_Q]);
    case (q)
      2'd0:    quant_sel = qv[0];
      2'd1:    quant_sel = qv[1];
      default: quant_sel = qv[2];
    endcase
  endfunction

  assign busy_now = lbusy & ~job.finish;
  assign job_pop  = (state == S_IDLE) && job_valid;

  assign link.busy  = lbusy;
  assign link.queue = cur;

  // Head reads: address for queue rd_cnt goes out while data of rd_cnt-1 comes back.
  always_comb begin
    ram_raddr = head_addr[NUM_Q-1];
    for (int q = 0; q < NUM_Q; q++) begin
      if (rd_cnt == 2'(q)) begin
        ram_raddr = head_addr[q];
      end
    end
  end

  // Saturating quantum add for a landing.
  assign add_sum = SMW'(deficit[cur]) + SMW'(quant_sel(cur, quantum));
  assign add_sat = (|add_sum[SMW-1:DW]) ? '1 : add_sum[DW-1:0];

  // Saturating add of a block of rounds in the closed-form step.
  assign acc_sum = PW'(deficit[idx]) + PW'(prod);
  assign acc_sat = (|acc_sum[PW-1:DW]) ? '1 : acc_sum[DW-1:0];

  assign rounds = (k <= kw) ? best : best - SW'(1);

  // Rounds still needed by queue idx: ceiling of the missing credit over its quantum.
  assign div_num = NW'(heads[idx]) - NW'(deficit[idx]) + NW'(quant_sel(idx, quantum)) - NW'(1);
  assign idx_ok  = nonempty[idx] && (quant_sel(idx, quantum) != 16'd0);
  assign div_start = (state == S_DSEL) && idx_ok;
  assign r_new   = div_quot[SW-1:0];

  assign ext_cur = {16'b0, heads[cur]};
  assign ext_w   = {16'b0, heads[w]};

  drr_div #(.W(NW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (NW'(quant_sel(idx, quantum))),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur         <= 2'd0;
      prev        <= QUEUE_NONE;
      lbusy       <= 1'b0;
      nonempty    <= '0;
      drop_r      <= 1'b0;
      rd_cnt      <= 2'd0;
      pass_cnt    <= 2'd0;
      k           <= 2'd0;
      idx         <= 2'd0;
      found       <= 1'b0;
      kw          <= 2'd0;
      w           <= 2'd0;
      done        <= 1'b0;
      grant_valid <= 1'b0;
      grant_queue <= 2'd0;
      grant_size  <= 16'd0;
      dropped     <= 1'b0;
      link_busy   <= 1'b0;
      for (int q = 0; q < NUM_Q; q++) begin
        deficit[q] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            drop_r   <= job.dropped;
            nonempty <= job.nonempty;
            lbusy    <= busy_now;
            if (busy_now || job.nonempty == '0) begin
              done        <= 1'b1;
              grant_valid <= 1'b0;
              grant_queue <= 2'd0;
              grant_size  <= 16'd0;
              dropped     <= job.dropped;
              link_busy   <= busy_now;
            end else begin
              rd_cnt <= 2'd0;
              state  <= S_READ;
            end
          end
        end
        S_READ: begin
          for (int q = 0; q < NUM_Q; q++) begin
            if (rd_cnt == 2'(q + 1)) begin
              heads[q] <= ram_rdata;
            end
          end
          rd_cnt <= rd_cnt + 2'd1;
          if (rd_cnt == 2'(NUM_Q)) begin
            pass_cnt <= 2'd0;
            state    <= S_ADD;
          end
        end
        S_ADD: begin
          if (cur != prev) begin
            deficit[cur] <= add_sat;
          end
          prev  <= cur;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (nonempty[cur] && DW'(heads[cur]) <= deficit[cur]) begin
            deficit[cur] <= deficit[cur] - DW'(heads[cur]);
            lbusy        <= 1'b1;
            done         <= 1'b1;
            grant_valid  <= 1'b1;
            grant_queue  <= cur;
            grant_size   <= ext_cur[15:0];
            dropped      <= drop_r;
            link_busy    <= 1'b1;
            state        <= S_IDLE;
          end else begin
            if (!nonempty[cur]) begin
              deficit[cur] <= '0;
            end
            cur <= next_q(cur);
            if (pass_cnt == 2'(NUM_Q - 1)) begin
              k     <= 2'd0;
              idx   <= next_q(cur);
              found <= 1'b0;
              state <= S_DSEL;
            end else begin
              pass_cnt <= pass_cnt + 2'd1;
              state    <= S_ADD;
            end
          end
        end
        S_DSEL, S_DWAIT: begin
          if ((state == S_DSEL && idx_ok) || (state == S_DWAIT && !div_done)) begin
            state <= S_DWAIT;
          end else begin
            if (state == S_DWAIT && (!found || r_new < best)) begin
              found <= 1'b1;
              best  <= r_new;
              kw    <= k;
              w     <= idx;
            end
            if (k == 2'(NUM_Q - 1)) begin
              k   <= 2'd0;
              idx <= cur;
              if (found || state == S_DWAIT) begin
                state <= S_MUL;
              end else begin
                done        <= 1'b1;
                grant_valid <= 1'b0;
                grant_queue <= 2'd0;
                grant_size  <= 16'd0;
                dropped     <= drop_r;
                link_busy   <= 1'b0;
                state       <= S_IDLE;
              end
            end else begin
              k     <= k + 2'd1;
              idx   <= next_q(idx);
              state <= S_DSEL;
            end
          end
        end
        S_MUL: begin
          prod  <= MW'(rounds) * MW'(quant_sel(idx, quantum));
          state <= S_ACC;
        end
        S_ACC: begin
          if (nonempty[idx]) begin
            deficit[idx] <= acc_sat;
          end
          if (k == 2'(NUM_Q - 1)) begin
            state <= S_FINAL;
          end else begin
            k     <= k + 2'd1;
            idx   <= next_q(idx);
            state <= S_MUL;
          end
        end
        S_FINAL: begin
          deficit[w]  <= deficit[w] - DW'(heads[w]);
          cur         <= w;
          prev        <= w;
          lbusy       <= 1'b1;
          done        <= 1'b1;
          grant_valid <= 1'b1;
          grant_queue <= w;
          grant_size  <= ext_w[15:0];
          dropped     <= drop_r;
          link_busy   <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/deficit_round_robin_scheduler_unit.sv @@
// Without a scan the engine answers straight from its idle state; a scan adds head reads,
// a landing per queue (add, then check), and when no head fits after one pass, up to 3
// divisions on a 17-bit divider at 16-bit sizes plus the closed-form credit steps.
// Throughput: one item at a time; busy falls at the edge that ends the done cycle.
// Reset (rst, synchronous): queues empty, deficits zero, link idle, quanta 1500; packet store
// contents stay undefined and need no clearing pass. The receiver cannot stall results.
module deficit_round_robin_scheduler_unit import drr_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int SIZE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [1:0]  queue_sel,
  input  logic [15:0] packet_size,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  output logic        done,
  output logic        grant_valid,
  output logic [1:0]  grant_queue,
  output logic [15:0] grant_size,
  output logic        dropped,
  output logic        link_busy
);

  // The design is split into a front part that owns the three packet FIFOs and a
  // scheduling engine that owns the deficits and the link. The front part applies an
  // enqueue or a pop at the start transfer and then hands a short job record through a
  // two-entry queue; the engine reads the queue heads and runs the round scan.
  localparam int AW = $clog2(NUM_Q * QUEUE_DEPTH);

  logic          accept;
  logic [15:0]   quantum [NUM_Q];

  link_t         link;
  job_t          push_job;
  job_t          pop_job;
  logic          job_push;
  logic          job_pop;
  logic          job_full;
  logic          job_empty;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [SIZE_BITS-1:0] ram_rdata;
  logic [AW-1:0] head_addr [NUM_Q];

  assign accept = start && !busy;

  // Busy covers the whole life of one item: it rises with the start transfer and falls
  // once the result has been shown for its one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  // Quantum registers. A write to an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_Q; q++) begin
        quantum[q] <= QUANTUM_RESET;
      end
    end else if (wr_en) begin
      case (wr_index)
        REG_QUANTUM_0: quantum[0] <= wr_data;
        REG_QUANTUM_1: quantum[1] <= wr_data;
        REG_QUANTUM_2: quantum[2] <= wr_data;
        default: ;
      endcase
    end
  end

  // Packet lengths of all three FIFOs share one store, each FIFO owning a slice of
  // QUEUE_DEPTH entries. The front part writes tails, the engine reads heads.
  drr_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (NUM_Q * QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  drr_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SIZE_BITS   (SIZE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (accept),
    .cmd         (cmd),
    .queue_sel   (queue_sel),
    .packet_size (packet_size),
    .link        (link),
    .job_full    (job_full),
    .job_push    (job_push),
    .job         (push_job),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .head_addr   (head_addr)
  );

  drr_jobq u_jobq (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (push_job),
    .pop       (job_pop),
    .pop_data  (pop_job),
    .full      (job_full),
    .empty     (job_empty)
  );

  // The engine produces exactly one result per job, with or without a grant.
  drr_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SIZE_BITS   (SIZE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (!job_empty),
    .job         (pop_job),
    .job_pop     (job_pop),
    .quantum     (quantum),
    .head_addr   (head_addr),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .link        (link),
    .done        (done),
    .grant_valid (grant_valid),
    .grant_queue (grant_queue),
    .grant_size  (grant_size),
    .dropped     (dropped),
    .link_busy   (link_busy)
  );

endmodule

@@ sim/deficit_round_robin_scheduler_unit_tb.sv @@
`timescale 1ns / 100ps

module deficit_round_robin_scheduler_unit_tb import drr_pkg::*; ();

  // Geometry of the block under test; the predictor keeps its own copy of every queue.
  localparam int          DEPTH      = 16;
  localparam longint      CREDIT_MAX = 64'd131071;   // all ones in a 17-bit deficit
  localparam int unsigned CYCLE_LIMIT = 500000;

  // One result of the scheduler, in the order of the result ports.
  typedef struct packed {
    logic        grant_valid;
    logic [1:0]  grant_queue;
    logic [15:0] grant_size;
    logic        dropped;
    logic        link_busy;
  } grant_rec_t;

  // One row of the directed table. When typed is set, want is the result to check
  // against; otherwise the predictor supplies it.
  typedef struct {
    logic        cmd;
    logic [1:0]  sel;
    logic [15:0] size;
    int          reps;
    bit          typed;
    grant_rec_t  want;
  } stim_row_t;

  localparam int N_ROWS = 11;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cmd;
  logic [1:0]  queue_sel;
  logic [15:0] packet_size;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [15:0] wr_data;
  logic        done;
  logic        grant_valid;
  logic [1:0]  grant_queue;
  logic [15:0] grant_size;
  logic        dropped;
  logic        link_busy;

  deficit_round_robin_scheduler_unit DUT (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Predictor state: the packet lengths held in each FIFO, the FIFO pointers, the
  // per-queue deficit, the round-robin pointer, the last queue landed on and the link.
  logic [15:0]     pkt_len_mem [NUM_Q][DEPTH];
  int unsigned     q_head [NUM_Q];
  int unsigned     q_tail [NUM_Q];
  int unsigned     q_fill [NUM_Q];
  longint unsigned credit [NUM_Q];
  longint unsigned quanta [NUM_Q];
  int unsigned     rr_ptr;
  int unsigned     last_visited;
  bit              link_on;

  grant_rec_t  expected_grants [$];
  stim_row_t   directed_rows [N_ROWS];
  int          mismatches;
  int unsigned cycle_count;
  int          gap_pct;

  function automatic longint unsigned credit_add(longint unsigned a, longint unsigned b);
    return (a + b > CREDIT_MAX) ? CREDIT_MAX : a + b;
  endfunction

  // Works out the result of one transfer and moves the predictor state along.
  function automatic grant_rec_t drr_schedule(logic c, logic [1:0] s, logic [15:0] sz);
    grant_rec_t      r;
    int unsigned     q, s0, kw, w, i, k;
    longint unsigned best, need, rounds;
    bit              found, granted;
    r = '0;
    found = 1'b0;
    granted = 1'b0;
    best = 0;
    kw = 0;
    w = 0;
    if (c == CMD_ENQUEUE) begin
      if (s >= NUM_Q || q_fill[s] >= DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        pkt_len_mem[s][q_tail[s]] = sz;
        q_tail[s] = (q_tail[s] + 1) % DEPTH;
        q_fill[s]++;
      end
    end else if (link_on) begin
      // The packet on the link is the head of the queue the pointer rests on.
      q = rr_ptr;
      if (q_fill[q] > 0) begin
        q_head[q] = (q_head[q] + 1) % DEPTH;
        q_fill[q]--;
      end
      link_on = 1'b0;
    end

    if (!link_on && (q_fill[0] != 0 || q_fill[1] != 0 || q_fill[2] != 0)) begin
      s0 = rr_ptr;
      // First pass: land on each queue once, crediting it unless it was the last one.
      for (k = 0; k < NUM_Q && !granted; k++) begin
        q = rr_ptr;
        if (q != last_visited) begin
          credit[q] = credit_add(credit[q], quanta[q]);
        end
        last_visited = q;
        if (q_fill[q] == 0) begin
          credit[q] = 0;
        end else if (pkt_len_mem[q][q_head[q]] <= credit[q]) begin
          credit[q] -= pkt_len_mem[q][q_head[q]];
          granted = 1'b1;
          w = q;
        end
        if (!granted) begin
          rr_ptr = (q + 1) % NUM_Q;
        end
      end
      // No head fits yet: find the queue that fits after the fewest further rounds,
      // ties going to the queue reached first from the starting point.
      if (!granted) begin
        for (k = 0; k < NUM_Q; k++) begin
          i = (s0 + k) % NUM_Q;
          if (q_fill[i] != 0 && quanta[i] != 0) begin
            need = (pkt_len_mem[i][q_head[i]] - credit[i] + quanta[i] - 1) / quanta[i];
            if (!found || need < best) begin
              found = 1'b1;
              best = need;
              kw = k;
              w = i;
            end
          end
        end
        if (found) begin
          for (k = 0; k < NUM_Q; k++) begin
            i = (s0 + k) % NUM_Q;
            rounds = (k <= kw) ? best : best - 1;
            if (q_fill[i] != 0) begin
              credit[i] = credit_add(credit[i], rounds * quanta[i]);
            end
          end
          credit[w] -= pkt_len_mem[w][q_head[w]];
          rr_ptr = w;
          last_visited = w;
          granted = 1'b1;
        end
      end
      if (granted) begin
        link_on = 1'b1;
      end
    end

    if (granted) begin
      r.grant_valid = 1'b1;
      r.grant_queue = w[1:0];
      r.grant_size  = pkt_len_mem[w][q_head[w]];
    end
    r.link_busy = link_on;
    return r;
  endfunction

  // Presents one item, waits for the start transfer and records what must come back.
  // A random idle burst may come first, while gap_pct is nonzero.
  task automatic send_item(input logic c, input logic [1:0] s, input logic [15:0] sz,
                           input bit typed, input grant_rec_t want);
    grant_rec_t r;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start       <= 1'b1;
    cmd         <= c;
    queue_sel   <= s;
    packet_size <= sz;
    // busy is read here before the block updates it, so this is the value at the edge.
    do @(posedge clk); while (busy);
    r = drr_schedule(c, s, sz);
    expected_grants = {expected_grants, typed ? want : r};
  endtask

  // Quanta are only rewritten once the block is idle and every result is in.
  task automatic write_quanta(input logic [15:0] q0, input logic [15:0] q1,
                              input logic [15:0] q2);
    start <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= REG_QUANTUM_0;
    wr_data  <= q0;
    @(posedge clk);
    wr_index <= REG_QUANTUM_1;
    wr_data  <= q1;
    @(posedge clk);
    wr_index <= REG_QUANTUM_2;
    wr_data  <= q2;
    @(posedge clk);
    wr_en <= 1'b0;
    quanta[0] = q0;
    quanta[1] = q1;
    quanta[2] = q2;
  endtask

  // Random traffic: mostly valid enqueues and finishes, a few to the missing queue,
  // with half the lengths between 1 and 2500, some at the extremes of the field and the rest random.
  task automatic random_traffic(input int items, input int finish_pct, input bit idle_ok);
    logic       c;
    logic [1:0] s;
    logic [15:0] sz;
    int         n;
    for (n = 0; n < items; n++) begin
      if (n % 32 == 0) begin
        gap_pct = idle_ok ? 12 * $urandom_range(0, 3) : 0;
      end
      c = ($urandom_range(0, 99) < finish_pct) ? CMD_FINISH : CMD_ENQUEUE;
      s = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
        0: begin
          sz = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        1, 2, 3, 4, 5: begin
          sz = 16'($urandom_range(1, 2500));
        end
        default: begin
          sz = 16'($urandom);
        end
      endcase
      send_item(c, s, sz, 1'b0, '0);
    end
  endtask

  // Checks every done strobe against the oldest outstanding expectation.
  always @(posedge clk) begin
    grant_rec_t want;
    grant_rec_t got;
    got = '{grant_valid, grant_queue, grant_size, dropped, link_busy};
    if (!rst && done) begin
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with nothing outstanding:", $realtime);
          $display("%0t: actual   valid %0d queue %0d size %0d drop %0d link %0d",
                   $realtime, got.grant_valid, got.grant_queue, got.grant_size, got.dropped,
                   got.link_busy);
        end
      end else begin
        want = expected_grants.pop_front();
        if (got.grant_valid !== want.grant_valid || got.grant_queue !== want.grant_queue ||
            got.grant_size !== want.grant_size || got.dropped !== want.dropped ||
            got.link_busy !== want.link_busy) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: expected valid %0d queue %0d size %0d drop %0d link %0d",
                     $realtime, want.grant_valid, want.grant_queue, want.grant_size,
                     want.dropped, want.link_busy);
            $display("%0t: actual   valid %0d queue %0d size %0d drop %0d link %0d",
                     $realtime, got.grant_valid, got.grant_queue, got.grant_size,
                     got.dropped, got.link_busy);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int r;
    int n;

    rst         <= 1'b1;
    start       <= 1'b0;
    cmd         <= CMD_ENQUEUE;
    queue_sel   <= 2'd0;
    packet_size <= 16'd0;
    wr_en       <= 1'b0;
    wr_index    <= REG_QUANTUM_0;
    wr_data     <= 16'd0;
    gap_pct     = 0;

    // Predictor reset; store contents are never read before they are written.
    for (n = 0; n < NUM_Q; n++) begin
      q_head[n] = 0;
      q_tail[n] = 0;
      q_fill[n] = 0;
      credit[n] = 0;
      quanta[n] = QUANTUM_RESET;
    end
    rr_ptr       = 0;
    last_visited = QUEUE_NONE;
    link_on      = 1'b0;

    // Directed sequence at the reset quanta. A finish while idle, an enqueue to the
    // missing queue, a first grant, a zero-length packet granted at the next finish,
    // a full-size packet reached only after several rounds, queue 0 filled to the
    // brim while the link is busy and one more enqueue that must be dropped.
    directed_rows = '{
      '{CMD_FINISH,  2'd0, 16'd0,    1, 1'b1, '{1'b0, 2'd0, 16'd0,    1'b0, 1'b0}},
      '{CMD_ENQUEUE, 2'd3, 16'hFFFF, 1, 1'b1, '{1'b0, 2'd0, 16'd0,    1'b1, 1'b0}},
      '{CMD_ENQUEUE, 2'd0, 16'd1000, 1, 1'b1, '{1'b1, 2'd0, 16'd1000, 1'b0, 1'b1}},
      '{CMD_ENQUEUE, 2'd1, 16'hFFFF, 1, 1'b1, '{1'b0, 2'd0, 16'd0,    1'b0, 1'b1}},
      '{CMD_ENQUEUE, 2'd2, 16'd0,    1, 1'b1, '{1'b0, 2'd0, 16'd0,    1'b0, 1'b1}},
      '{CMD_FINISH,  2'd0, 16'd0,    1, 1'b0, '0},
      '{CMD_FINISH,  2'd1, 16'd0,    1, 1'b0, '0},
      '{CMD_ENQUEUE, 2'd0, 16'd1,    8, 1'b0, '0},
      '{CMD_ENQUEUE, 2'd0, 16'd1501, 8, 1'b0, '0},
      '{CMD_ENQUEUE, 2'd0, 16'd7,    1, 1'b1, '{1'b0, 2'd0, 16'd0,    1'b1, 1'b1}},
      '{CMD_FINISH,  2'd2, 16'hFFFF, 3, 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < N_ROWS; r++) begin
      for (n = 0; n < directed_rows[r].reps; n++) begin
        send_item(directed_rows[r].cmd, directed_rows[r].sel, directed_rows[r].size,
                  directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // Random phases, each at its own quanta. The largest and smallest nonzero quanta come
    // first; the all-zero phase leaves only zero-length packets able to go, so the
    // scan gives up after one pass and the queues fill and drop. The later phases
    // drain that backlog.
    write_quanta(16'hFFFF, 16'd1, 16'd700);
    random_traffic(120, 40, 1'b1);
    write_quanta(16'd1, 16'd1, 16'd1);
    random_traffic(100, 45, 1'b1);
    write_quanta(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                 16'($urandom_range(1, 4000)));
    random_traffic(120, 30, 1'b1);
    write_quanta(16'd0, 16'd0, 16'd0);
    random_traffic(40, 50, 1'b1);
    write_quanta(16'd900, 16'd0, 16'hFFFF);
    random_traffic(120, 45, 1'b1);
    write_quanta(QUANTUM_RESET, QUANTUM_RESET, QUANTUM_RESET);
    random_traffic(120, 45, 1'b1);
    // Closing part back to back, without idle gaps.
    write_quanta(16'($urandom_range(1, 3000)), 16'($urandom_range(1, 3000)),
                 16'($urandom_range(1, 3000)));
    random_traffic(130, 45, 1'b0);

    start <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/drr_pkg.sv
hdl/drr_ram.sv
hdl/drr_front.sv
hdl/drr_jobq.sv
hdl/drr_div.sv
hdl/drr_back.sv
hdl/deficit_round_robin_scheduler_unit.sv
sim/deficit_round_robin_scheduler_unit_tb.sv
